// ===== rtl/trigger_id_extend_event_ring_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trigger id extension block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIGGER_ID_EXTEND_EVENT_RING_DEFINES_SVH
`define TRIGGER_ID_EXTEND_EVENT_RING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TIDX_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tidx assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TIDX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tidx assertion failed");

`endif

// ===== rtl/tidx_pkg.sv =====
// ----------------------------------------------------------------------------
// tidx_pkg
// Types, codes and sizes shared by the trigger id extension block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tidx_pkg;

    // Ring size. The slot of a count is its low bits, so the depth is a
    // power of two.
    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam logic [15:0] GAP_LIMIT_RESET = 16'd200;

    // Action codes of an input word.
    localparam logic [2:0] ACT_FRAME = 3'd0;
    localparam logic [2:0] ACT_PEEK  = 3'd1;
    localparam logic [2:0] ACT_POP   = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;
    localparam logic [2:0] ACT_START = 3'd4;
    localparam logic [2:0] ACT_STOP  = 3'd5;

    // Status codes of a result word.
    localparam logic [3:0] ST_STORED   = 4'd0;
    localparam logic [3:0] ST_STOPPED  = 4'd1;
    localparam logic [3:0] ST_OVERFLOW = 4'd2;
    localparam logic [3:0] ST_BAD      = 4'd3;
    localparam logic [3:0] ST_FRONT    = 4'd4;
    localparam logic [3:0] ST_EMPTY    = 4'd5;
    localparam logic [3:0] ST_POPPED   = 4'd6;
    localparam logic [3:0] ST_CLEARED  = 4'd7;
    localparam logic [3:0] ST_RUN_DONE = 4'd8;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] frame_tag;
        logic [15:0] counter_low;
    } tidx_in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] out_tag;
        logic [31:0] trigger_id;
        logic [8:0]  occupancy;
        logic [31:0] input_total;
        logic [31:0] bad_total;
        logic [31:0] overflow_total;
        logic [31:0] first_trigger;
    } tidx_out_t;

    // One ring entry: frame tag plus its extended id.
    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] id;
    } tidx_entry_t;

endpackage

// ===== rtl/trigger_id_extend_event_ring.sv =====
// ----------------------------------------------------------------------------
// trigger_id_extend_event_ring
// Extends 16-bit trigger counters to 32-bit ids and keeps frames in a ring.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            word
//   in        input      in_valid/in_ready    in_data  (action, tag, counter)
//   out       output     out_valid/out_ready  out_data (status, entry, totals)
//   cfg       input      cfg_we               cfg_wdata (gap limit)
//
// A word is captured in the input register and then resolved into the result
// register, so one word is taken per cycle while the result is not stalled.
// The front of the ring is prefetched into a read register every cycle,
// which lets a peek or pop follow a write with no bubble.
// Reset needs no clearing pass; ring entries hold no reset value.
// A stalled result holds the input register; undefined actions give no word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trigger_id_extend_event_ring_defines.svh"

module trigger_id_extend_event_ring
    import tidx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tidx_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output tidx_out_t   out_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    // Handshake registers.
    logic        in_valid_reg;
    tidx_in_t    in_data_reg;
    logic        out_valid_reg, out_valid_next;
    tidx_out_t   out_data_reg, out_data_next;

    // Block state.
    logic [31:0]        wt_reg, wt_next;
    logic [31:0]        rt_reg, rt_next;
    logic [RING_AW-1:0] guard_reg, guard_next;
    logic [31:0]        expected_reg, expected_next;
    logic               awaiting_reg, awaiting_next;
    logic               accepting_reg, accepting_next;
    logic [31:0]        start_id_reg, start_id_next;
    logic [31:0]        received_reg, received_next;
    logic [31:0]        broken_reg, broken_next;
    logic [31:0]        full_reg, full_next;
    logic [15:0]        gap_reg;

    // Ring interface.
    logic               mem_we;
    tidx_entry_t        mem_wdata;
    tidx_entry_t        front;

    // Trigger extension terms.
    logic [31:0] exp_base;
    logic [31:0] guess0, guess1;
    logic        jump0_ok, jump1_ok, id_match;
    logic        proc;
    logic        emit;
    logic [3:0]  status_c;
    logic [15:0] otag_c;
    logic [31:0] oid_c;
    logic [31:0] occ_full;

    tidx_ring u_ring (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wt_reg[RING_AW-1:0]),
        .wr_data (mem_wdata),
        .rd_addr (rt_next[RING_AW-1:0]),
        .rd_data (front)
    );

    // Handshake: a word is resolved when the result register is free.
    assign proc      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Candidate ids for the arriving counter, without and with a 16-bit wrap.
    assign exp_base = awaiting_reg ? {16'd0, in_data_reg.counter_low} : expected_reg;
    assign id_match = (in_data_reg.counter_low == exp_base[15:0]);
    assign guess0   = {exp_base[31:16], in_data_reg.counter_low};
    assign guess1   = {exp_base[31:16] + 16'd1, in_data_reg.counter_low};
    assign jump0_ok = (guess0 > exp_base) && ((guess0 - exp_base) < {16'd0, gap_reg});
    assign jump1_ok = (guess1 > exp_base) && ((guess1 - exp_base) < {16'd0, gap_reg});

    assign mem_wdata.tag = in_data_reg.frame_tag;
    assign mem_wdata.id  = jump0_ok && !id_match ? guess0 :
                           (jump1_ok && !id_match ? guess1 : exp_base);

    // Action decode and next state.
    always_comb
    begin
        wt_next        = wt_reg;
        rt_next        = rt_reg;
        guard_next     = guard_reg;
        expected_next  = expected_reg;
        awaiting_next  = awaiting_reg;
        accepting_next = accepting_reg;
        start_id_next  = start_id_reg;
        received_next  = received_reg;
        broken_next    = broken_reg;
        full_next      = full_reg;
        mem_we         = 1'b0;
        emit           = 1'b1;
        status_c       = ST_RUN_DONE;
        otag_c         = 16'd0;
        oid_c          = 32'd0;

        if (proc)
        begin
            unique case (in_data_reg.action)
                ACT_FRAME:
                begin
                    if (!accepting_reg)
                    begin
                        status_c = ST_STOPPED;
                    end
                    else
                    begin
                        received_next = received_reg + 32'd1;
                        if (wt_reg[RING_AW-1:0] == guard_reg)
                        begin
                            full_next = full_reg + 32'd1;
                            status_c  = ST_OVERFLOW;
                        end
                        else
                        begin
                            awaiting_next = 1'b0;
                            if (awaiting_reg)
                            begin
                                start_id_next = exp_base;
                            end
                            if (!id_match && !jump0_ok && !jump1_ok)
                            begin
                                // Broken trigger: drop it but keep counting ids.
                                expected_next = exp_base + 32'd1;
                                broken_next   = broken_reg + 32'd1;
                                status_c      = ST_BAD;
                            end
                            else
                            begin
                                mem_we        = 1'b1;
                                otag_c        = mem_wdata.tag;
                                oid_c         = mem_wdata.id;
                                wt_next       = wt_reg + 32'd1;
                                expected_next = mem_wdata.id + 32'd1;
                                status_c      = ST_STORED;
                            end
                        end
                    end
                end
                ACT_PEEK, ACT_POP:
                begin
                    if (wt_reg == rt_reg)
                    begin
                        status_c = ST_EMPTY;
                    end
                    else
                    begin
                        guard_next = rt_reg[RING_AW-1:0];
                        otag_c     = front.tag;
                        oid_c      = front.id;
                        if (in_data_reg.action == ACT_POP)
                        begin
                            rt_next  = rt_reg + 32'd1;
                            status_c = ST_POPPED;
                        end
                        else
                        begin
                            status_c = ST_FRONT;
                        end
                    end
                end
                ACT_CLEAR:
                begin
                    wt_next  = rt_reg;
                    status_c = ST_CLEARED;
                end
                ACT_START:
                begin
                    wt_next        = 32'd0;
                    rt_next        = 32'd0;
                    guard_next     = RING_AW'(RING_DEPTH - 1);
                    expected_next  = 32'd0;
                    awaiting_next  = 1'b1;
                    start_id_next  = 32'd0;
                    received_next  = 32'd0;
                    broken_next    = 32'd0;
                    full_next      = 32'd0;
                    accepting_next = 1'b1;
                end
                ACT_STOP:
                begin
                    accepting_next = 1'b0;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // Result word from the state after the action.
    assign occ_full = wt_next - rt_next;

    always_comb
    begin
        out_data_next.status         = status_c;
        out_data_next.out_tag        = otag_c;
        out_data_next.trigger_id     = oid_c;
        out_data_next.occupancy      = occ_full[8:0];
        out_data_next.input_total    = received_next;
        out_data_next.bad_total      = broken_next;
        out_data_next.overflow_total = full_next;
        out_data_next.first_trigger  = start_id_next;
    end

    // Result valid follows a resolved word or drops when taken.
    always_comb
    begin
        if (proc)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wt_reg        <= 32'd0;
            rt_reg        <= 32'd0;
            guard_reg     <= RING_AW'(RING_DEPTH - 1);
            expected_reg  <= 32'd0;
            awaiting_reg  <= 1'b1;
            accepting_reg <= 1'b0;
            start_id_reg  <= 32'd0;
            received_reg  <= 32'd0;
            broken_reg    <= 32'd0;
            full_reg      <= 32'd0;
            gap_reg       <= GAP_LIMIT_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            wt_reg        <= wt_next;
            rt_reg        <= rt_next;
            guard_reg     <= guard_next;
            expected_reg  <= expected_next;
            awaiting_reg  <= awaiting_next;
            accepting_reg <= accepting_next;
            start_id_reg  <= start_id_next;
            received_reg  <= received_next;
            broken_reg    <= broken_next;
            full_reg      <= full_next;
            if (cfg_we)
            begin
                gap_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (proc)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks on ring bookkeeping.
    `TIDX_ASSERT_SAME(a_occ_bound, 1'b1, (wt_reg - rt_reg) <= 32'(RING_DEPTH))
    `TIDX_ASSERT_SAME(a_stored_occ, out_valid_reg && (out_data_reg.status == ST_STORED),
        out_data_reg.occupancy != 9'd0)
    `TIDX_ASSERT_SAME(a_empty_occ, out_valid_reg && (out_data_reg.status == ST_EMPTY),
        out_data_reg.occupancy == 9'd0)
    `TIDX_ASSERT_NEXT(a_stopped_hold,
        proc && (in_data_reg.action == ACT_FRAME) && !accepting_reg,
        (wt_reg == $past(wt_reg)) && (received_reg == $past(received_reg)))

endmodule

// ===== rtl/tidx_ring.sv =====
// ----------------------------------------------------------------------------
// tidx_ring
// Event ring storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tidx_ring
    import tidx_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [RING_AW-1:0] wr_addr,
    input  tidx_entry_t        wr_data,
    input  logic [RING_AW-1:0] rd_addr,
    output tidx_entry_t        rd_data
);

    tidx_entry_t ring_mem [RING_DEPTH];
    tidx_entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

    // Read port. A write to the slot being read in the same cycle is passed
    // through, so the front entry is always current.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
